### rtl/fxc_pkg.sv
// shared types and constants for the frame parser with xor checksum
package fxc_pkg;

    localparam logic [7:0] START_RESET = 8'hA5;
    localparam int unsigned SEQ_BYTES = 4;
    localparam int unsigned ADDR_W = 3;
    localparam logic [ADDR_W-1:0] ADDR_START_VALUE = 3'd0;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_GOOD      = 2'd1,
        KIND_BAD_START = 2'd2,
        KIND_BAD_CSUM  = 2'd3
    } result_kind_t;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_SEQ    = 7'b0000010,
        PH_TYPE   = 7'b0000100,
        PH_LEN    = 7'b0001000,
        PH_PAY    = 7'b0010000,
        PH_CSUM   = 7'b0100000,
        PH_REJECT = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_first;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [31:0] sequence_number;
        logic [7:0]  message_type;
        logic [7:0]  frame_length;
        logic        end_of_frame;
    } out_item_t;

endpackage

### rtl/frame_parser_xor_checksum_unit.sv
// top level: apb register, input register and frame parser
// an accepted byte passes the input register and then the result register on its way to its result beat
// throughput: one byte per cycle while the result register is not full, set by the single-pass parse logic
// bytes that give no result pass the input register without waiting on the output
// reset: parser idle, all header and checksum state zero, start_value 0xA5
// output beats are held until taken; no clearing pass is needed after reset
module frame_parser_xor_checksum_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  fxc_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output fxc_pkg::out_item_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fxc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fxc_pkg::*;

    logic       start_sel;
    logic [7:0] start_value_reg;
    logic       hold_valid_reg, hold_valid_next;
    in_item_t   hold_reg;
    logic       take;
    logic       in_fire;

    assign start_sel = (paddr == ADDR_START_VALUE);
    assign pready    = 1'b1;
    assign prdata    = start_sel ? {24'd0, start_value_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= START_RESET;
        end
        else if (psel && penable && pwrite && pready && start_sel)
        begin
            start_value_reg <= pwdata[7:0];
        end
    end

    assign in_ready = !hold_valid_reg || take;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
        end
        else if (take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            hold_reg <= in_data;
        end
    end

    fxc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (hold_valid_reg),
        .item        (hold_reg),
        .start_value (start_value_reg),
        .item_take   (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

### rtl/fxc_parser.sv
// frame parse state, checksum tracking and result register
module fxc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  fxc_pkg::in_item_t item,
    input  logic [7:0]        start_value,
    output logic              item_take,
    output logic              out_valid,
    input  logic              out_ready,
    output fxc_pkg::out_item_t out_data
);
    import fxc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] seq_reg, seq_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  len_reg, len_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        emit;
    out_item_t   result;
    logic        out_free;
    logic [7:0]  count_inc;

    assign count_inc = count_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        xor_next   = xor_reg;
        seq_next   = seq_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        emit       = 1'b0;
        result     = '0;
        if (item.frame_first)
        begin
            seq_next   = '0;
            type_next  = '0;
            len_next   = '0;
            count_next = '0;
            if (item.rx_byte != start_value)
            begin
                xor_next           = '0;
                phase_next         = PH_REJECT;
                emit               = 1'b1;
                result.result_kind = KIND_BAD_START;
                result.end_of_frame = 1'b1;
            end
            else
            begin
                xor_next   = item.rx_byte;
                phase_next = PH_SEQ;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_SEQ:
                begin
                    xor_next   = xor_reg ^ item.rx_byte;
                    seq_next   = {seq_reg[23:0], item.rx_byte};
                    count_next = count_inc;
                    if (count_inc >= 8'(SEQ_BYTES))
                    begin
                        count_next = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    xor_next   = xor_reg ^ item.rx_byte;
                    type_next  = item.rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    xor_next   = xor_reg ^ item.rx_byte;
                    len_next   = item.rx_byte;
                    count_next = '0;
                    phase_next = (item.rx_byte == 8'd0) ? PH_CSUM : PH_PAY;
                end
                PH_PAY:
                begin
                    xor_next   = xor_reg ^ item.rx_byte;
                    count_next = count_inc;
                    if (count_inc == len_reg)
                    begin
                        phase_next = PH_CSUM;
                    end
                    emit                   = 1'b1;
                    result.result_kind     = KIND_PAYLOAD;
                    result.payload_byte    = item.rx_byte;
                    result.sequence_number = seq_reg;
                    result.message_type    = type_reg;
                    result.frame_length    = len_reg;
                end
                PH_CSUM:
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                    emit       = 1'b1;
                    result.result_kind = (item.rx_byte == xor_reg) ? KIND_GOOD
                                                                   : KIND_BAD_CSUM;
                    result.sequence_number = seq_reg;
                    result.message_type    = type_reg;
                    result.frame_length    = len_reg;
                    result.end_of_frame    = 1'b1;
                end
                default:
                begin
                    // idle or rejecting: stray bytes are dropped
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    // a byte with no result never waits on the output side
    assign item_take = item_valid && (!emit || out_free);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (item_take && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            xor_reg       <= '0;
            seq_reg       <= '0;
            type_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                xor_reg   <= xor_next;
                seq_reg   <= seq_next;
                type_reg  <= type_next;
                len_reg   <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### dv/frame_parser_xor_checksum_checker.sv
// checker for the frame parser: predicts result beats from accepted bytes and compares them
`timescale 1ns / 1ps

module frame_parser_xor_checksum_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  fxc_pkg::in_item_t           in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  fxc_pkg::out_item_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [fxc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output int unsigned                 errors,
    output int unsigned                 pending
);
    import fxc_pkg::*;

    logic [7:0]  start_byte;
    phase_t      phase;
    logic [7:0]  count;
    logic [7:0]  csum;
    logic [31:0] seq_num;
    logic [7:0]  msg_type;
    logic [7:0]  pay_len;
    out_item_t   owed_results[$];

    task automatic parse_rx_byte(input in_item_t item);
        out_item_t  res;
        logic [7:0] b;
        res = '0;
        b = item.rx_byte;
        if (item.frame_first)
        begin
            // a first flag always restarts, dropping any frame in progress silently
            seq_num  = '0;
            msg_type = '0;
            pay_len  = '0;
            count    = '0;
            if (b != start_byte)
            begin
                csum = '0;
                phase = PH_REJECT;
                res.result_kind  = KIND_BAD_START;
                res.end_of_frame = 1'b1;
                owed_results.push_back(res);
            end
            else
            begin
                csum = b;
                phase = PH_SEQ;
            end
        end
        else
        begin
            case (phase)
                PH_SEQ:
                begin
                    csum ^= b;
                    seq_num = {seq_num[23:0], b};
                    count = count + 8'd1;
                    if (count >= SEQ_BYTES)
                    begin
                        count = '0;
                        phase = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    csum ^= b;
                    msg_type = b;
                    phase = PH_LEN;
                end
                PH_LEN:
                begin
                    csum ^= b;
                    pay_len = b;
                    count = '0;
                    phase = (b == 8'd0) ? PH_CSUM : PH_PAY;
                end
                PH_PAY:
                begin
                    csum ^= b;
                    count = count + 8'd1;
                    if (count == pay_len)
                        phase = PH_CSUM;
                    res.result_kind     = KIND_PAYLOAD;
                    res.payload_byte    = b;
                    res.sequence_number = seq_num;
                    res.message_type    = msg_type;
                    res.frame_length    = pay_len;
                    owed_results.push_back(res);
                end
                PH_CSUM:
                begin
                    phase = PH_IDLE;
                    count = '0;
                    res.result_kind     = (b == csum) ? KIND_GOOD : KIND_BAD_CSUM;
                    res.sequence_number = seq_num;
                    res.message_type    = msg_type;
                    res.frame_length    = pay_len;
                    res.end_of_frame    = 1'b1;
                    owed_results.push_back(res);
                end
                default:
                    ; // idle or rejecting: stray bytes are dropped
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_beat(input out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
            errors++;
            return;
        end
        want = owed_results.pop_front();
        compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        compare_field("sequence_number", want.sequence_number, got.sequence_number);
        compare_field("message_type", 32'(want.message_type), 32'(got.message_type));
        compare_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
        compare_field("end_of_frame", 32'(want.end_of_frame), 32'(got.end_of_frame));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte = START_RESET;
            phase      = PH_IDLE;
            count      = '0;
            csum       = '0;
            seq_num    = '0;
            msg_type   = '0;
            pay_len    = '0;
            owed_results.delete();
            errors     = 0;
            pending   <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_START_VALUE)
                start_byte = pwdata[7:0];
            // compare before predicting: a byte accepted now cannot have its beat out yet
            if (out_valid && out_ready)
                check_beat(out_data);
            if (in_valid && in_ready)
                parse_rx_byte(in_data);
            pending <= owed_results.size();
        end
    end

endmodule

### dv/frame_parser_xor_checksum_unit_test.sv
// testbench top for the frame parser: byte stimulus, register writes and verdict
`timescale 1ns / 1ps

module frame_parser_xor_checksum_unit_test;
    import fxc_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    int unsigned errors;
    int unsigned pending;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          sent = 0;
    int          stall_cycles = 0;
    logic [7:0]  cur_start = START_RESET;

    frame_parser_xor_checksum_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    frame_parser_xor_checksum_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // watchdog: no beat moving on any port for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{rx_byte: b, frame_first: first};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // cut < 0 sends the whole frame, else only the first cut bytes
    task automatic send_frame(input logic [7:0] sb, input logic [31:0] seq,
                              input logic [7:0] mtype, input int len,
                              input bit bad_csum, input int cut);
        logic [7:0] bytes[$];
        logic [7:0] x;
        int         n;
        bytes = {sb, seq[31:24], seq[23:16], seq[15:8], seq[7:0], mtype, 8'(len)};
        for (int i = 0; i < len; i++)
            bytes.push_back(8'($urandom_range(0, 255)));
        x = '0;
        foreach (bytes[i])
            x ^= bytes[i];
        if (bad_csum)
            x ^= 8'($urandom_range(1, 255));
        bytes.push_back(x);
        n = (cut < 0) ? bytes.size() : cut;
        for (int i = 0; i < n; i++)
            send_byte(bytes[i], i == 0);
    endtask

    // hold off the sender until every owed beat is out and the pipe is empty
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_START_VALUE;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_start = value;
    endtask

    task automatic run_random(input int target);
        int         stop;
        int         r;
        int         len;
        logic [7:0] v;
        stop = sent + target;
        while (sent < stop)
        begin
            if ($urandom_range(0, 39) == 0)
                wait_drained();
            r = $urandom_range(0, 99);
            len = $urandom_range(0, 99);
            if (len < 85)
                len = $urandom_range(0, 12);
            else if (len < 99)
                len = $urandom_range(13, 40);
            else
                len = 255;
            if (r < 60)
                send_frame(cur_start, $urandom, 8'($urandom_range(0, 255)), len, 1'b0, -1);
            else if (r < 75)
                send_frame(cur_start, $urandom, 8'($urandom_range(0, 255)), len, 1'b1, -1);
            else if (r < 85)
                // frame cut after a random number of bytes, at most the whole frame; the next first flag drops it
                send_frame(cur_start, $urandom, 8'($urandom_range(0, 255)), len, 1'b0,
                           $urandom_range(1, len + 7));
            else if (r < 93)
            begin
                v = cur_start ^ 8'($urandom_range(1, 255));
                send_byte(v, 1'b1);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial
    begin
        tx_idle_pct = 8;
        rx_idle_pct = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte while idle, bad start then a byte in reject, header extremes,
        // zero length, bad checksum, and a frame cut by a new first flag
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_frame(START_RESET, 32'hFFFF_FFFF, 8'hFF, 0, 1'b0, -1);
        send_frame(START_RESET, 32'h0000_0000, 8'h00, 1, 1'b1, -1);
        send_frame(START_RESET, 32'h1234_5678, 8'h5A, 3, 1'b0, 3);
        send_frame(START_RESET, 32'h8000_0001, 8'h01, 2, 1'b0, -1);

        wait_drained();
        write_start(8'h00);
        run_random(640);

        wait_drained();
        write_start(8'hFF);
        tx_idle_pct = 71;
        rx_idle_pct = 8;
        run_random(640);

        wait_drained();
        write_start(8'($urandom_range(0, 255)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(640);

        wait_drained();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
